>>> hdl/idl_pkg.sv
// shared types and constants for the indexed deque list
// used by idl_cell, idl_ctrl and indexed_deque_list_top; no dependencies
package idl_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int VAL_W  = 16;
    localparam int FUNC_W = 3;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 5;
    localparam int ST_W   = 2;
    localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 24;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD_FRONT = 3'd0,
        FN_ADD_REAR  = 3'd1,
        FN_REM_FRONT = 3'd2,
        FN_REM_REAR  = 3'd3,
        FN_INSERT_AT = 3'd4,
        FN_REMOVE_AT = 3'd5
    } t_func;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] idx;
    } t_cell_cmd;

endpackage

>>> hdl/idl_cell.sv
// one storage cell of the list row: holds one slot and shifts with its neighbors
// depends on idl_pkg
module idl_cell (
    input  logic                       i_clk,
    input  idl_pkg::t_cell_cmd         i_cmd,
    input  logic [idl_pkg::IDX_W-1:0]  i_index,
    input  logic [idl_pkg::VAL_W-1:0]  i_value,
    input  logic [idl_pkg::VAL_W-1:0]  i_left,
    input  logic [idl_pkg::VAL_W-1:0]  i_right,
    output logic [idl_pkg::VAL_W-1:0]  o_slot
);

    logic [idl_pkg::VAL_W-1:0] r_slot;
    logic [idl_pkg::VAL_W-1:0] n_slot;

    always_comb begin
        n_slot = r_slot;
        case (i_cmd.op)
            idl_pkg::OP_INSERT: begin
                if (i_index == i_cmd.idx) begin
                    n_slot = i_value;
                end else if (i_index > i_cmd.idx) begin
                    n_slot = i_left;
                end
            end
            idl_pkg::OP_REMOVE: begin
                // everything from the hole rearward pulls one place forward
                if (i_index >= i_cmd.idx) begin
                    n_slot = i_right;
                end
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

>>> hdl/idl_ctrl.sv
// list controller: element count, range and fill checks, cell row command
// depends on idl_pkg
module idl_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [idl_pkg::FUNC_W-1:0]  i_func,
    input  logic [idl_pkg::POS_W-1:0]   i_position,
    output idl_pkg::t_cell_cmd          o_cmd,
    output idl_pkg::t_status            o_status,
    output logic [idl_pkg::CNT_W-1:0]   o_count
);

    logic [idl_pkg::CNT_W-1:0] r_count;
    logic [idl_pkg::CNT_W-1:0] n_count;
    logic [idl_pkg::CMP_W-1:0] w_pos;
    logic [idl_pkg::CMP_W-1:0] w_cnt;
    logic                      w_full;
    logic                      w_empty;
    logic [idl_pkg::IDX_W-1:0] w_pos_idx;
    logic [idl_pkg::IDX_W-1:0] w_rear_idx;
    logic [idl_pkg::IDX_W-1:0] w_last_idx;
    idl_pkg::t_cell_op         w_op;
    logic [idl_pkg::IDX_W-1:0] w_idx;
    idl_pkg::t_status          w_status;

    assign w_pos      = idl_pkg::CMP_W'(i_position);
    assign w_cnt      = idl_pkg::CMP_W'(r_count);
    assign w_full     = (r_count == idl_pkg::CNT_W'(idl_pkg::DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_pos_idx  = idl_pkg::IDX_W'(w_pos - idl_pkg::CMP_W'(1));
    assign w_rear_idx = idl_pkg::IDX_W'(r_count);
    assign w_last_idx = idl_pkg::IDX_W'(r_count - idl_pkg::CNT_W'(1));

    always_comb begin
        w_op     = idl_pkg::OP_HOLD;
        w_idx    = '0;
        w_status = idl_pkg::ST_OK;
        case (idl_pkg::t_func'(i_func))
            idl_pkg::FN_ADD_FRONT, idl_pkg::FN_ADD_REAR: begin
                if (w_full) begin
                    w_status = idl_pkg::ST_FULL;
                end else begin
                    w_op  = idl_pkg::OP_INSERT;
                    w_idx = (idl_pkg::t_func'(i_func) == idl_pkg::FN_ADD_FRONT)
                            ? '0 : w_rear_idx;
                end
            end
            idl_pkg::FN_REM_FRONT, idl_pkg::FN_REM_REAR: begin
                if (w_empty) begin
                    w_status = idl_pkg::ST_UNDERFLOW;
                end else begin
                    w_op  = idl_pkg::OP_REMOVE;
                    w_idx = (idl_pkg::t_func'(i_func) == idl_pkg::FN_REM_FRONT)
                            ? '0 : w_last_idx;
                end
            end
            idl_pkg::FN_INSERT_AT: begin
                // range check comes before the full check
                if (w_pos == '0 || w_pos > w_cnt + idl_pkg::CMP_W'(1)) begin
                    w_status = idl_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = idl_pkg::ST_FULL;
                end else begin
                    w_op  = idl_pkg::OP_INSERT;
                    w_idx = w_pos_idx;
                end
            end
            idl_pkg::FN_REMOVE_AT: begin
                if (w_pos == '0 || w_pos > w_cnt) begin
                    w_status = idl_pkg::ST_RANGE;
                end else begin
                    w_op  = idl_pkg::OP_REMOVE;
                    w_idx = w_pos_idx;
                end
            end
            default: begin
                w_status = idl_pkg::ST_RANGE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_fire && w_op == idl_pkg::OP_INSERT) begin
            n_count = r_count + idl_pkg::CNT_W'(1);
        end else if (i_fire && w_op == idl_pkg::OP_REMOVE) begin
            n_count = r_count - idl_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_cmd.op  = i_fire ? w_op : idl_pkg::OP_HOLD;
    assign o_cmd.idx = w_idx;
    assign o_status  = w_status;
    assign o_count   = n_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= idl_pkg::CNT_W'(idl_pkg::DEPTH))
        else $error("element count above depth");

    a_fail_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_status != idl_pkg::ST_OK) |=> $stable(r_count))
        else $error("failed operation changed the count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == idl_pkg::OP_INSERT) |=>
        (r_count == $past(r_count) + idl_pkg::CNT_W'(1)))
        else $error("insert did not grow the count");

endmodule

>>> hdl/indexed_deque_list_top.sv
// indexed deque list: ordered list with insert and remove at ends or by position
// a result beat is registered and appears in the cycle after its input beat is taken
// throughput: one beat per cycle while the result side takes its beats; the whole cell row shifts in the same cycle
// the output register frees the input side whenever the result is taken
// reset (i_rst_n, synchronous, low) empties the list and drops the output beat
// depends on idl_pkg, idl_ctrl and idl_cell
module indexed_deque_list_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [idl_pkg::IN_W-1:0]  s_axis_tdata,   // position[4:0], value[20:5], zeros
    input  logic [idl_pkg::FUNC_W-1:0] s_axis_tuser,  // func[2:0]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [idl_pkg::OUT_W-1:0] m_axis_tdata    // removed_value[15:0], status[17:16],
                                                      // length[22:18], zero[23]
);

    logic                        w_s_fire;
    logic [idl_pkg::POS_W-1:0]   w_position;
    logic [idl_pkg::VAL_W-1:0]   w_value;
    idl_pkg::t_cell_cmd          w_cmd;
    idl_pkg::t_status            w_status;
    logic [idl_pkg::CNT_W-1:0]   w_count;
    logic [idl_pkg::VAL_W-1:0]   w_slot [idl_pkg::DEPTH];
    logic [idl_pkg::VAL_W-1:0]   w_removed;

    logic                        r_out_valid;
    logic [idl_pkg::VAL_W-1:0]   r_removed;
    idl_pkg::t_status            r_status;
    logic [idl_pkg::LEN_W-1:0]   r_length;

    assign w_position    = s_axis_tdata[idl_pkg::POS_W-1:0];
    assign w_value       = s_axis_tdata[idl_pkg::POS_W +: idl_pkg::VAL_W];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_s_fire      = s_axis_tvalid && s_axis_tready;

    idl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_s_fire),
        .i_func     (s_axis_tuser),
        .i_position (w_position),
        .o_cmd      (w_cmd),
        .o_status   (w_status),
        .o_count    (w_count)
    );

    for (genvar g = 0; g < idl_pkg::DEPTH; g++) begin : g_cell
        logic [idl_pkg::VAL_W-1:0] w_left;
        logic [idl_pkg::VAL_W-1:0] w_right;

        // front cell never takes from the left, rear cell refills itself
        if (g == 0) begin : g_front
            assign w_left = w_value;
        end else begin : g_mid_l
            assign w_left = w_slot[g-1];
        end
        if (g == idl_pkg::DEPTH - 1) begin : g_rear
            assign w_right = w_slot[g];
        end else begin : g_mid_r
            assign w_right = w_slot[g+1];
        end

        idl_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (idl_pkg::IDX_W'(g)),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_slot  (w_slot[g])
        );
    end

    assign w_removed = (w_cmd.op == idl_pkg::OP_REMOVE) ? w_slot[w_cmd.idx] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_removed <= w_removed;
            r_status  <= w_status;
            r_length  <= idl_pkg::LEN_W'(w_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = idl_pkg::OUT_W'({r_length, r_status, r_removed});

    a_fire_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_fire |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

    a_removed_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_removed != '0) |-> (r_status == idl_pkg::ST_OK))
        else $error("removed value on a failed operation");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_length <= idl_pkg::LEN_W'(idl_pkg::DEPTH)))
        else $error("reported length above depth");

endmodule

>>> tb/tb.sv
// self-checking bench for indexed_deque_list_top: a shadow list predicts every result beat
// depends on idl_pkg and the rtl under hdl/; stimulus is directed corner cases then random ops
module tb;

    localparam logic [idl_pkg::FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [idl_pkg::FUNC_W-1:0] FN_SPARE_B = 3'd7;
    localparam int ST_LO  = idl_pkg::VAL_W;
    localparam int LEN_LO = idl_pkg::VAL_W + idl_pkg::ST_W;
    localparam int RANDOM_OPS = 1100;

    typedef struct packed {
        logic [idl_pkg::VAL_W-1:0] removed;
        idl_pkg::t_status          status;
        logic [idl_pkg::LEN_W-1:0] length;
    } t_list_result;

    // shadow copy of the list and the beats it still owes
    class list_tracker;
        logic [idl_pkg::VAL_W-1:0] slots [idl_pkg::DEPTH];
        int unsigned               count;
        t_list_result              pending_results [$];
        int unsigned               errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void push_at(int unsigned at, logic [idl_pkg::VAL_W-1:0] val);
            int unsigned i;
            for (i = count; i > at; i--) slots[i] = slots[i-1];
            slots[at] = val;
            count++;
        endfunction

        function logic [idl_pkg::VAL_W-1:0] pull_at(int unsigned at);
            int unsigned               i;
            logic [idl_pkg::VAL_W-1:0] v;
            v = slots[at];
            for (i = at; i + 1 < count; i++) slots[i] = slots[i+1];
            count--;
            return v;
        endfunction

        function void take_op(logic [idl_pkg::FUNC_W-1:0] func,
                              logic [idl_pkg::POS_W-1:0] pos,
                              logic [idl_pkg::VAL_W-1:0] val);
            t_list_result r;
            r.removed = '0;
            r.status  = idl_pkg::ST_OK;
            case (func)
                idl_pkg::FN_ADD_FRONT, idl_pkg::FN_ADD_REAR: begin
                    if (count >= idl_pkg::DEPTH) r.status = idl_pkg::ST_FULL;
                    else push_at((func == idl_pkg::FN_ADD_FRONT) ? 0 : count, val);
                end
                idl_pkg::FN_REM_FRONT, idl_pkg::FN_REM_REAR: begin
                    if (count == 0) r.status = idl_pkg::ST_UNDERFLOW;
                    else r.removed = pull_at((func == idl_pkg::FN_REM_FRONT) ? 0 : count - 1);
                end
                idl_pkg::FN_INSERT_AT: begin
                    // position check wins over the full check
                    if (pos < 1 || pos > count + 1) r.status = idl_pkg::ST_RANGE;
                    else if (count >= idl_pkg::DEPTH) r.status = idl_pkg::ST_FULL;
                    else push_at(pos - 1, val);
                end
                idl_pkg::FN_REMOVE_AT: begin
                    if (pos < 1 || pos > count) r.status = idl_pkg::ST_RANGE;
                    else r.removed = pull_at(pos - 1);
                end
                default: r.status = idl_pkg::ST_RANGE;
            endcase
            r.length = idl_pkg::LEN_W'(count);
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [idl_pkg::VAL_W-1:0] got,
                    logic [idl_pkg::VAL_W-1:0] want);
            $display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h",
                     what, $time, got, want);
            errors++;
        endtask

        task check_beat(logic [idl_pkg::OUT_W-1:0] data);
            t_list_result want;
            if (pending_results.size() == 0) begin
                report("unexpected result beat", data[idl_pkg::VAL_W-1:0], '0);
                return;
            end
            want = pending_results.pop_front();
            if (data[idl_pkg::VAL_W-1:0] !== want.removed)
                report("removed_value", data[idl_pkg::VAL_W-1:0], want.removed);
            if (data[ST_LO +: idl_pkg::ST_W] !== want.status)
                report("status", idl_pkg::VAL_W'(data[ST_LO +: idl_pkg::ST_W]),
                       idl_pkg::VAL_W'(want.status));
            if (data[LEN_LO +: idl_pkg::LEN_W] !== want.length)
                report("length", idl_pkg::VAL_W'(data[LEN_LO +: idl_pkg::LEN_W]),
                       idl_pkg::VAL_W'(want.length));
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [idl_pkg::IN_W-1:0]     s_axis_tdata;   // position[4:0], value[20:5], zeros
    logic [idl_pkg::FUNC_W-1:0]   s_axis_tuser;   // func[2:0]
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [idl_pkg::OUT_W-1:0]    m_axis_tdata;   // removed_value[15:0], status[17:16],
                                                  // length[22:18]

    list_tracker sb = new();
    int unsigned burst_left;

    indexed_deque_list_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    // results are checked before the input of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.take_op(s_axis_tuser, s_axis_tdata[idl_pkg::POS_W-1:0],
                           s_axis_tdata[idl_pkg::POS_W +: idl_pkg::VAL_W]);
        end
    end

    // receiver backpressure, switching between a few stall patterns
    initial begin
        int unsigned mode;
        int unsigned span;
        int unsigned run;
        logic        hold;
        m_axis_tready = 1'b0;
        run  = 0;
        hold = 1'b0;
        forever begin
            mode = $urandom_range(3);
            span = $urandom_range(64, 256);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = 1'($urandom_range(1));
                    2: begin
                        if (run == 0) begin
                            hold = ~hold;
                            run  = $urandom_range(1, 8);
                        end
                        run--;
                        m_axis_tready = hold;
                    end
                    default: m_axis_tready = ($urandom_range(15) != 0);
                endcase
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the beat is taken, or later when an idle gap follows
    task automatic send_op(input logic [idl_pkg::FUNC_W-1:0] func,
                           input logic [idl_pkg::POS_W-1:0] pos,
                           input logic [idl_pkg::VAL_W-1:0] val);
        logic        taken;
        int unsigned gap;
        s_axis_tuser  = func;
        s_axis_tdata  = {{(idl_pkg::IN_W-idl_pkg::POS_W-idl_pkg::VAL_W){1'b0}}, val, pos};
        s_axis_tvalid = 1'b1;
        do begin
            @(posedge i_clk);
            taken = s_axis_tready;
            @(negedge i_clk);
        end while (!taken);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic random_op(input logic grow);
        int unsigned                r;
        logic [idl_pkg::FUNC_W-1:0] func;
        logic [idl_pkg::POS_W-1:0]  pos;
        r   = $urandom_range(99);
        pos = idl_pkg::POS_W'($urandom_range(31));
        if (r < 4) begin
            func = $urandom_range(1) ? FN_SPARE_B : FN_SPARE_A;
        end else if ((r < 65) == grow) begin
            case ($urandom_range(2))
                0: func = idl_pkg::FN_ADD_FRONT;
                1: func = idl_pkg::FN_ADD_REAR;
                default: begin
                    func = idl_pkg::FN_INSERT_AT;
                    if ($urandom_range(9) != 0)
                        pos = idl_pkg::POS_W'($urandom_range(1, sb.count + 1));
                end
            endcase
        end else begin
            case ($urandom_range(2))
                0: func = idl_pkg::FN_REM_FRONT;
                1: func = idl_pkg::FN_REM_REAR;
                default: begin
                    func = idl_pkg::FN_REMOVE_AT;
                    if (sb.count > 0 && $urandom_range(9) != 0)
                        pos = idl_pkg::POS_W'($urandom_range(1, sb.count));
                end
            endcase
        end
        send_op(func, pos, idl_pkg::VAL_W'($urandom));
    endtask

    initial begin
        int unsigned n;
        int unsigned phase_left;
        logic        grow;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        burst_left    = $urandom_range(1, 20);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty list corners, then range and spare-function checks on a short list
        send_op(idl_pkg::FN_REM_FRONT, 5'd0, 16'h0000);
        send_op(idl_pkg::FN_REM_REAR,  5'd0, 16'h0000);
        send_op(idl_pkg::FN_REMOVE_AT, 5'd1, 16'h0000);
        send_op(idl_pkg::FN_INSERT_AT, 5'd0, 16'h1111);
        send_op(idl_pkg::FN_INSERT_AT, 5'd2, 16'h2222);
        send_op(idl_pkg::FN_INSERT_AT, 5'd1, 16'hFFFF);
        send_op(idl_pkg::FN_ADD_FRONT, 5'd31, 16'h0000);
        send_op(idl_pkg::FN_ADD_REAR,  5'd0, 16'hA5A5);
        send_op(FN_SPARE_A,            5'd1, 16'h5A5A);
        send_op(FN_SPARE_B,            5'd1, 16'h5A5A);
        send_op(idl_pkg::FN_REMOVE_AT, 5'd0, 16'h0000);
        send_op(idl_pkg::FN_REMOVE_AT, 5'd31, 16'h0000);
        send_op(idl_pkg::FN_INSERT_AT, 5'd4, 16'h1234);
        send_op(idl_pkg::FN_REMOVE_AT, 5'd2, 16'h0000);
        // fill up, then hit the full list
        while (sb.count < idl_pkg::DEPTH)
            send_op(idl_pkg::FN_ADD_REAR, 5'd0, idl_pkg::VAL_W'($urandom));
        send_op(idl_pkg::FN_ADD_FRONT, 5'd0, 16'hBEEF);
        send_op(idl_pkg::FN_INSERT_AT, 5'd17, 16'hBEEF);
        send_op(idl_pkg::FN_INSERT_AT, 5'd18, 16'hBEEF);
        send_op(idl_pkg::FN_ADD_REAR,  5'd0, 16'hBEEF);
        send_op(idl_pkg::FN_REMOVE_AT, 5'd16, 16'h0000);

        // random ops, drifting between growing and shrinking phases
        grow       = 1'b0;
        phase_left = 0;
        for (n = 0; n < RANDOM_OPS; n++) begin
            if (phase_left == 0) begin
                grow       = ~grow;
                phase_left = $urandom_range(30, 80);
            end
            phase_left--;
            random_op(grow);
        end
        s_axis_tvalid = 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> files.f
hdl/idl_pkg.sv
hdl/idl_cell.sv
hdl/idl_ctrl.sv
hdl/indexed_deque_list_top.sv
tb/tb.sv
